>>> rtl/tcf_pkg.sv
// Package for the tilt complementary filter: types, constants and the CORDIC arctangent table.
// Used by tcf_ctrl, tcf_datapath and tilt_complementary_filter.
package tcf_pkg;

   localparam int CORDIC_ITER_DEF = 16;
   localparam int ATAN_ENTRIES    = 24;
   localparam int MULT_STEPS      = 6;
   localparam int STEP_W          = 6;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_REFERENCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_TOLERANCE = 2'd2;

   localparam logic [16:0] BLEND_WEIGHT_RESET      = 17'd64225;
   localparam logic [14:0] GRAVITY_REFERENCE_RESET = 15'd16384;
   localparam logic [14:0] GRAVITY_TOLERANCE_RESET = 15'd2458;
   localparam logic [16:0] WEIGHT_ONE              = 17'd65536;

   localparam logic signed [32:0] PI_Q28    = 33'sd843314857;

   // divide by 10^6 after the 2^17 scale reduces to a divide by 15625 with rounding 7812
   localparam logic [13:0] DIV_CORE     = 14'd15625;
   localparam logic [12:0] ROUND_CORE   = 13'd7812;
   // ceil(2^45 / 15625), exact for numerators below 2^31
   localparam logic [31:0] RECIP_WIDE   = 32'd2251799814;
   // ceil(2^39 / 15625), exact for numerators below 2^25
   localparam logic [25:0] RECIP_NARROW = 26'd35184373;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MULT, ST_ITER, ST_PREP, ST_BLO, ST_BHI, ST_FINISH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      MS_NONE, MS_RATE, MS_AX, MS_AY, MS_AZ, MS_LO, MS_HI, MS_BLO, MS_BHI
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        cordic_step;
      logic [4:0]  cordic_idx;
      logic        prep;
      logic        finish;
   } dp_cmd_type;

   function automatic logic [27:0] atan_q28(input logic [4:0] idx);
      logic [27:0] v;
      case (idx)
         5'd0: v = 28'd210828714;
         5'd1: v = 28'd124459457;
         5'd2: v = 28'd65760959;
         5'd3: v = 28'd33381290;
         5'd4: v = 28'd16755422;
         5'd5: v = 28'd8385879;
         5'd6: v = 28'd4193963;
         5'd7: v = 28'd2097109;
         5'd8: v = 28'd1048571;
         5'd9: v = 28'd524287;
         5'd10: v = 28'd262144;
         5'd11: v = 28'd131072;
         5'd12: v = 28'd65536;
         5'd13: v = 28'd32768;
         5'd14: v = 28'd16384;
         5'd15: v = 28'd8192;
         5'd16: v = 28'd4096;
         5'd17: v = 28'd2048;
         5'd18: v = 28'd1024;
         5'd19: v = 28'd512;
         5'd20: v = 28'd256;
         5'd21: v = 28'd128;
         5'd22: v = 28'd64;
         5'd23: v = 28'd32;
         default: v = 28'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/tcf_ctrl.sv
// Controller for the tilt complementary filter: sequences multiply, iterate, blend and output.
// Depends on tcf_pkg; drives tcf_datapath through a command struct.
module tcf_ctrl #(
   parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output tcf_pkg::dp_cmd_type cmd
);
   import tcf_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.mul_sel = MS_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               step_in     = '0;
               state_in    = ST_MULT;
            end
         end
         ST_MULT: begin
            case (step_ff)
               6'd0: cmd.mul_sel = MS_RATE;
               6'd1: cmd.mul_sel = MS_AX;
               6'd2: cmd.mul_sel = MS_AY;
               6'd3: cmd.mul_sel = MS_AZ;
               6'd4: cmd.mul_sel = MS_LO;
               default: cmd.mul_sel = MS_HI;
            endcase
            if (step_ff == STEP_W'(MULT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_ITER;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ITER: begin
            cmd.cordic_step = 1'b1;
            cmd.cordic_idx  = step_ff[4:0];
            if (step_ff == STEP_W'(CORDIC_ITERATIONS - 1)) begin
               state_in = ST_PREP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_BLO;
         end
         ST_BLO: begin
            cmd.mul_sel = MS_BLO;
            state_in    = ST_BHI;
         end
         ST_BHI: begin
            cmd.mul_sel = MS_BHI;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/tcf_datapath.sv
// Datapath for the tilt complementary filter: shared multiplier, divider, CORDIC, blend.
// Depends on tcf_pkg; commanded by tcf_ctrl.
module tcf_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tcf_pkg::dp_cmd_type cmd,
   input  logic signed [15:0]  accel_x,
   input  logic signed [15:0]  accel_y,
   input  logic signed [15:0]  accel_z,
   input  logic signed [15:0]  gyro_rate,
   input  logic [15:0]         elapsed_us,
   input  logic                init_from_accel,
   input  logic [16:0]         blend_weight,
   input  logic [14:0]         gravity_reference,
   input  logic [14:0]         gravity_tolerance,
   output logic signed [31:0]  tilt_angle_out,
   output logic signed [15:0]  angle_rate,
   output logic                accel_used,
   output logic                angle_saturated
);
   import tcf_pkg::*;

   logic signed [15:0] ax_ff, ay_ff, az_ff, rate_ff;
   logic [15:0]        us_ff;
   logic               init_ff;

   logic [32:0]        mag_ff;
   logic [31:0]        lo2_ff, hi2_ff;
   logic [30:0]        p_ff;
   logic [17:0]        q1_ff;
   logic [24:0]        n2_ff;
   logic [28:0]        quo_ff;
   logic               neg_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [32:0] ang_ff;
   logic               zero_ff;
   logic signed [32:0] gyro_ff, acc_ff;
   logic signed [33:0] diff_ff;
   logic               win_ff;
   logic [16:0]        a_ff;
   logic signed [53:0] sum_ff;
   logic signed [31:0] tilt_ff;

   logic signed [17:0] op_a, op_b;
   logic signed [35:0] prod;
   logic [15:0]        abs_rate, abs_ax, abs_ay, abs_az, hi_v;
   logic [14:0]        lo_v;

   always_comb begin
      abs_rate = rate_ff[15] ? 16'(-rate_ff) : rate_ff;
      abs_ax   = ax_ff[15] ? 16'(-ax_ff) : ax_ff;
      abs_ay   = ay_ff[15] ? 16'(-ay_ff) : ay_ff;
      abs_az   = az_ff[15] ? 16'(-az_ff) : az_ff;
      lo_v     = (gravity_reference > gravity_tolerance) ?
                 gravity_reference - gravity_tolerance : 15'd0;
      hi_v     = {1'b0, gravity_reference} + {1'b0, gravity_tolerance};
      case (cmd.mul_sel)
         MS_RATE: begin op_a = {2'b0, abs_rate};    op_b = {2'b0, us_ff};  end
         MS_AX:   begin op_a = {2'b0, abs_ax};      op_b = {2'b0, abs_ax}; end
         MS_AY:   begin op_a = {2'b0, abs_ay};      op_b = {2'b0, abs_ay}; end
         MS_AZ:   begin op_a = {2'b0, abs_az};      op_b = {2'b0, abs_az}; end
         MS_LO:   begin op_a = {3'b0, lo_v};        op_b = {3'b0, lo_v};   end
         MS_HI:   begin op_a = {2'b0, hi_v};        op_b = {2'b0, hi_v};   end
         MS_BLO:  begin op_a = {1'b0, a_ff}; op_b = {1'b0, diff_ff[16:0]}; end
         MS_BHI:  begin op_a = {1'b0, a_ff}; op_b = {diff_ff[33], diff_ff[33:17]}; end
         default: begin op_a = '0; op_b = '0; end
      endcase
      prod = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ax_ff   <= accel_x;
         ay_ff   <= accel_y;
         az_ff   <= accel_z;
         rate_ff <= gyro_rate;
         us_ff   <= elapsed_us;
         init_ff <= init_from_accel;
      end
   end

   // multiplier products, divider and CORDIC seed
   logic signed [33:0] x0, y0;
   always_comb begin
      x0 = {{4{az_ff[15]}}, az_ff, 14'b0};
      y0 = {{4{ax_ff[15]}}, ax_ff, 14'b0};
   end

   // split |rate|*us into 15625*q1 + r1, then divide (r1*2048 + 7812) by 15625
   logic [62:0]        q1_prod;
   logic [31:0]        r1_v;
   logic [24:0]        n2_v;
   logic [50:0]        q2_prod;
   logic signed [33:0] xs, ys;
   logic signed [32:0] atan_v;
   always_comb begin
      q1_prod = {32'b0, p_ff} * {31'b0, RECIP_WIDE};
      r1_v    = {1'b0, p_ff} - {14'b0, q1_ff} * {18'b0, DIV_CORE};
      n2_v    = {r1_v[13:0], 11'b0} + {12'b0, ROUND_CORE};
      q2_prod = {26'b0, n2_ff} * {25'b0, RECIP_NARROW};
      xs      = x_ff >>> cmd.cordic_idx;
      ys      = y_ff >>> cmd.cordic_idx;
      atan_v  = $signed({5'b0, atan_q28(cmd.cordic_idx)});
   end

   always_ff @(posedge clock) begin
      q1_ff  <= q1_prod[62:45];
      n2_ff  <= n2_v;
      quo_ff <= {q1_ff, 11'b0} + {17'b0, q2_prod[50:39]};
   end

   always_ff @(posedge clock) begin
      case (cmd.mul_sel)
         MS_RATE: begin
            p_ff    <= prod[30:0];
            neg_ff  <= rate_ff[15];
            zero_ff <= (ax_ff == 16'sd0) && (az_ff == 16'sd0);
            if (az_ff[15]) begin
               x_ff   <= -x0;
               y_ff   <= -y0;
               ang_ff <= ax_ff[15] ? -PI_Q28 : PI_Q28;
            end else begin
               x_ff   <= x0;
               y_ff   <= y0;
               ang_ff <= '0;
            end
         end
         MS_AX: mag_ff <= {1'b0, prod[31:0]};
         MS_AY: mag_ff <= mag_ff + {1'b0, prod[31:0]};
         MS_AZ: mag_ff <= mag_ff + {1'b0, prod[31:0]};
         MS_LO: lo2_ff <= prod[31:0];
         MS_HI: hi2_ff <= prod[31:0];
         MS_BLO: sum_ff <= ({{21{acc_ff[32]}}, acc_ff} <<< 16) + 54'sd32768
                           + {{18{prod[35]}}, prod};
         MS_BHI: sum_ff <= sum_ff + ({{18{prod[35]}}, prod} <<< 17);
         default: ;
      endcase
      if (cmd.cordic_step) begin
         if (!y_ff[33]) begin
            x_ff   <= x_ff + ys;
            y_ff   <= y_ff - xs;
            ang_ff <= ang_ff + atan_v;
         end else begin
            x_ff   <= x_ff - ys;
            y_ff   <= y_ff + xs;
            ang_ff <= ang_ff - atan_v;
         end
      end
   end

   // gyro prediction, accelerometer angle and window test
   logic signed [32:0] q_s, gyro_v, acc_v;
   always_comb begin
      q_s    = $signed({4'b0, quo_ff});
      gyro_v = {tilt_ff[31], tilt_ff} + (neg_ff ? -q_s : q_s);
      acc_v  = zero_ff ? 33'sd0 : ang_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         gyro_ff <= gyro_v;
         acc_ff  <= acc_v;
         diff_ff <= {gyro_v[32], gyro_v} - {acc_v[32], acc_v};
         win_ff  <= (mag_ff >= {1'b0, lo2_ff}) && (mag_ff <= {1'b0, hi2_ff});
         a_ff    <= (blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight;
      end
   end

   // saturate and commit
   logic signed [36:0] pre_sat;
   logic signed [31:0] res_v;
   logic               used_v, sat_v;
   always_comb begin
      pre_sat = win_ff ? sum_ff[52:16] : {{4{gyro_ff[32]}}, gyro_ff};
      used_v  = 1'b1;
      sat_v   = 1'b0;
      res_v   = acc_ff[31:0];
      if (!init_ff) begin
         used_v = win_ff;
         if (pre_sat > 37'sh007FFFFFFF) begin
            res_v = 32'sh7FFFFFFF;
            sat_v = 1'b1;
         end else if (pre_sat < -37'sh0080000000) begin
            res_v = 32'sh80000000;
            sat_v = 1'b1;
         end else begin
            res_v = pre_sat[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_ff <= '0;
      end else if (cmd.finish) begin
         tilt_ff <= res_v;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         tilt_angle_out  <= res_v;
         angle_rate      <= rate_ff;
         accel_used      <= used_v;
         angle_saturated <= sat_v;
      end
   end

endmodule

>>> rtl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: configuration registers and stream ports.
// Depends on tcf_pkg, tcf_ctrl and tcf_datapath.
//
//   channel  direction  handshake          payload
//   req      in         req_tvalid/tready  req_tdata (80 bits), req_tuser (1 bit)
//   rsp      out        rsp_tvalid/tready  rsp_tdata (48 bits), rsp_tuser (2 bits)
//   csr      in         csr_we             csr_index (2 bits), csr_wdata (17 bits)
//
// One transaction runs from acceptance to result as 6 steps on the shared 18x18 multiplier,
// then CORDIC_ITERATIONS CORDIC steps while the reciprocal divide by 10^6 settles, then
// the blend prep, low-half and high-half steps and the output load.
// The next transaction is accepted the cycle after the result is loaded.
// Reset is synchronous and clears the angle and the configuration to defaults.
// A stalled rsp side holds the result; the block waits before loading the next.
module tilt_complementary_filter #(
   parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // accel_x, accel_y, accel_z, gyro_rate, elapsed_us
   input  logic [79:0]                        req_tdata,
   // init_from_accel
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tilt_angle_out, angle_rate
   output logic [47:0]                        rsp_tdata,
   // accel_used, angle_saturated
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tcf_pkg::*;

   logic [16:0] blend_weight_ff;
   logic [14:0] gravity_reference_ff, gravity_tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_weight_ff      <= BLEND_WEIGHT_RESET;
         gravity_reference_ff <= GRAVITY_REFERENCE_RESET;
         gravity_tolerance_ff <= GRAVITY_TOLERANCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLEND_WEIGHT:      blend_weight_ff      <= csr_wdata;
            CSR_GRAVITY_REFERENCE: gravity_reference_ff <= csr_wdata[14:0];
            CSR_GRAVITY_TOLERANCE: gravity_tolerance_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   dp_cmd_type         cmd;
   logic signed [31:0] tilt_angle_out;
   logic signed [15:0] angle_rate;
   logic               accel_used, angle_saturated;

   tcf_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tcf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .accel_x           (req_tdata[15:0]),
      .accel_y           (req_tdata[31:16]),
      .accel_z           (req_tdata[47:32]),
      .gyro_rate         (req_tdata[63:48]),
      .elapsed_us        (req_tdata[79:64]),
      .init_from_accel   (req_tuser[0]),
      .blend_weight      (blend_weight_ff),
      .gravity_reference (gravity_reference_ff),
      .gravity_tolerance (gravity_tolerance_ff),
      .tilt_angle_out    (tilt_angle_out),
      .angle_rate        (angle_rate),
      .accel_used        (accel_used),
      .angle_saturated   (angle_saturated)
   );

   assign rsp_tdata = {angle_rate, tilt_angle_out};
   assign rsp_tuser = {angle_saturated, accel_used};

endmodule

>>> sim/tb.sv
// Self-checking bench for tilt_complementary_filter: directed table, then random IMU samples.
// Predicts angle, rate and flags per transaction; depends on tcf_pkg and the RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcf_pkg::*;

   localparam longint ANG_MAX = 64'sd2147483647;
   localparam longint ANG_MIN = -64'sd2147483648;
   localparam int     RAND_ITEMS = 1330;
   localparam int     STALL_LIMIT = 20000;

   typedef struct packed {
      logic               init;
      logic [15:0]        us;
      logic signed [15:0] rate;
      logic signed [15:0] az;
      logic signed [15:0] ay;
      logic signed [15:0] ax;
   } sample_type;

   typedef struct packed {
      logic               sat;
      logic               used;
      logic signed [15:0] rate;
      logic signed [31:0] angle;
   } tilt_type;

   typedef struct {
      sample_type s;
      logic       known;
      tilt_type   r;
   } vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, rsp_tready = 1'b0, csr_we = 1'b0;
   logic req_tready, rsp_tvalid;
   logic [79:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BLEND_WEIGHT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tilt_complementary_filter dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and configuration
   longint   angle_q28;
   longint   weight, grav_ref, grav_tol;
   tilt_type pending_tilt[$];
   int       errors, n_rsp, n_used, n_sat, n_init, idle_cycles;
   int       send_idle_pct, recv_idle_pct;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint accel_angle(longint num, longint den);
      longint x, y, a, xs, ys;
      x = den * 16384; y = num * 16384; a = 0;
      if (num == 0 && den == 0) return 0;
      if (x < 0) begin
         a = (y >= 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
         x = -x; y = -y;
      end
      for (int i = 0; i < CORDIC_ITER_DEF && i < ATAN_ENTRIES; i++) begin
         xs = fshift(x, i); ys = fshift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; a += longint'(atan_q28(i[4:0]));
         end else begin
            x -= ys; y += xs; a -= longint'(atan_q28(i[4:0]));
         end
      end
      return a;
   endfunction

   function automatic tilt_type fuse_sample(sample_type s);
      tilt_type t;
      longint   acc, prod, mag, d, gyro, m2, lo, hi, a, res;
      acc = accel_angle(s.ax, s.az);
      t.rate = s.rate; t.sat = 1'b0; t.used = 1'b0;
      if (s.init) begin
         res = acc; t.used = 1'b1;
      end else begin
         prod = longint'(s.rate) * longint'({1'b0, s.us}) * 131072;
         mag = (prod < 0) ? -prod : prod;
         d = (mag + 500000) / 1000000;
         gyro = angle_q28 + ((prod < 0) ? -d : d);
         m2 = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
         lo = (grav_ref > grav_tol) ? grav_ref - grav_tol : 0;
         hi = grav_ref + grav_tol;
         if (m2 >= lo * lo && m2 <= hi * hi) begin
            a = (weight > 65536) ? 65536 : weight;
            res = fshift(a * gyro + (65536 - a) * acc + 32768, 16);
            t.used = 1'b1;
         end else begin
            res = gyro;
         end
         if (res > ANG_MAX) begin res = ANG_MAX; t.sat = 1'b1; end
         if (res < ANG_MIN) begin res = ANG_MIN; t.sat = 1'b1; end
      end
      angle_q28 = res;
      t.angle = res[31:0];
      return t;
   endfunction

   // response checking and stall watchdog
   always @(posedge clock) begin
      tilt_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[1], rsp_tuser[0], rsp_tdata[47:32], rsp_tdata[31:0]};
         got.used = rsp_tuser[0]; got.sat = rsp_tuser[1];
         n_rsp++;
         if (pending_tilt.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction angle=%0d", $time, got.angle);
         end else begin
            want = pending_tilt.pop_front();
            if (got.angle !== want.angle || got.rate !== want.rate ||
                got.used !== want.used || got.sat !== want.sat) begin
               errors++;
               $display("%0t: mismatch exp angle=%0d rate=%0d used=%b sat=%b", $time,
                        want.angle, want.rate, want.used, want.sat);
               $display("%0t:          got angle=%0d rate=%0d used=%b sat=%b", $time,
                        got.angle, got.rate, got.used, got.sat);
            end
            n_used += want.used; n_sat += want.sat;
         end
      end
      if (!reset && (rsp_tvalid && rsp_tready || req_tvalid && req_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint v);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BLEND_WEIGHT:      weight = v & 64'h1FFFF;
         CSR_GRAVITY_REFERENCE: grav_ref = v & 64'h7FFF;
         CSR_GRAVITY_TOLERANCE: grav_tol = v & 64'h7FFF;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_tilt.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {s.us, s.rate, s.az, s.ay, s.ax};
      req_tuser <= s.init;
      pending_tilt.push_back(fuse_sample(s));
      n_init += s.init;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic sample_type rand_sample();
      sample_type s;
      int         g, th;
      s = sample_type'(81'({$urandom, $urandom, $urandom}));
      s.init = ($urandom_range(19) == 0);
      case ($urandom_range(3))
         0, 1: begin
            // near one g so the accelerometer blend engages
            g = 16384 + $urandom_range(5000) - 2500;
            th = $urandom_range(0, 360);
            s.ax = 16'($rtoi(g * $sin(th * 3.14159265 / 180.0)));
            s.az = 16'($rtoi(g * $cos(th * 3.14159265 / 180.0)));
            s.ay = 16'(int'($urandom_range(600)) - 300);
            s.rate = 16'(int'($urandom_range(8000)) - 4000);
            s.us = 16'($urandom_range(2000, 8000));
         end
         2: s.us = 16'($urandom_range(20000));
         default: ;
      endcase
      return s;
   endfunction

   vec_type table_rows[$];

   function automatic void add_row(int ax, int ay, int az, int rate, int us, bit init,
                                   bit known = 0, int ang = 0, bit used = 0, bit sat = 0);
      vec_type v;
      v.s.ax = 16'(ax); v.s.ay = 16'(ay); v.s.az = 16'(az); v.s.rate = 16'(rate);
      v.s.us = 16'(us); v.s.init = init;
      v.known = known;
      v.r.angle = ang; v.r.rate = 16'(rate); v.r.used = used; v.r.sat = sat;
      table_rows.push_back(v);
   endfunction

   initial begin
      sample_type s;
      errors = 0; n_rsp = 0; n_used = 0; n_sat = 0; n_init = 0; idle_cycles = 0;
      send_idle_pct = 6; recv_idle_pct = 74;
      angle_q28 = 0;
      weight = BLEND_WEIGHT_RESET; grav_ref = GRAVITY_REFERENCE_RESET;
      grav_tol = GRAVITY_TOLERANCE_RESET;

      // zero accel, zero time after reset: angle stays zero
      add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(0, 0, 0, 1234, 0, 1, 1, 0, 1, 0);
      add_row(0, 0, 16384, 0, 0, 1);
      add_row(16384, 0, 0, 0, 0, 1);
      add_row(0, 0, -16384, 0, 0, 1);
      add_row(-100, 0, -16384, 0, 0, 1);
      add_row(100, 0, -16384, 0, 0, 1);
      add_row(-32768, -32768, -32768, -32768, 65535, 1);
      add_row(32767, 32767, 32767, 32767, 65535, 0);
      add_row(0, 0, 0, 32767, 65535, 0);
      for (int i = 0; i < 10; i++) add_row(0, 0, 0, 32767, 65535, 0);
      add_row(0, 0, 0, -32768, 65535, 0);
      for (int i = 0; i < 20; i++) add_row(0, 0, 0, -32768, 65535, 0);
      add_row(0, 0, 16384, -5, 3, 0);
      add_row(0, 0, 16384, 5, 3, 0);
      add_row(11585, 0, 11585, 100, 5000, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         send_sample(table_rows[i].s);
         if (table_rows[i].known && pending_tilt[$] != table_rows[i].r) begin
            errors++;
            $display("%0t: table row %0d predictor disagrees with typed result", $time, i);
         end
      end

      // hold until every result is back, then sweep configurations
      drain_results();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_BLEND_WEIGHT, 0);
               write_reg(CSR_GRAVITY_REFERENCE, 32767);
               write_reg(CSR_GRAVITY_TOLERANCE, 32767);
            end
            1: begin
               write_reg(CSR_BLEND_WEIGHT, 131071);
               write_reg(CSR_GRAVITY_REFERENCE, 16384);
               write_reg(CSR_GRAVITY_TOLERANCE, 0);
            end
            2: begin
               write_reg(CSR_BLEND_WEIGHT, 65536);
               write_reg(CSR_GRAVITY_REFERENCE, 100);
               write_reg(CSR_GRAVITY_TOLERANCE, 20000);
            end
            3: begin
               send_idle_pct = 74; recv_idle_pct = 6;
               write_reg(CSR_BLEND_WEIGHT, $urandom_range(65536));
               write_reg(CSR_GRAVITY_REFERENCE, 0);
               write_reg(CSR_GRAVITY_TOLERANCE, 4000);
            end
            4: begin
               write_reg(CSR_BLEND_WEIGHT, 64225);
               write_reg(CSR_GRAVITY_REFERENCE, 16384);
               write_reg(CSR_GRAVITY_TOLERANCE, 2458);
            end
            default: begin
               send_idle_pct = 0; recv_idle_pct = 0;
               write_reg(CSR_BLEND_WEIGHT, $urandom_range(131071));
               write_reg(CSR_GRAVITY_REFERENCE, $urandom_range(12000, 20000));
               write_reg(CSR_GRAVITY_TOLERANCE, $urandom_range(32767));
            end
         endcase
         for (int k = 0; k < RAND_ITEMS / 6; k++) begin
            s = rand_sample();
            send_sample(s);
         end
         drain_results();
      end

      $display("Covered %0d transactions: %0d blended or initialized, %0d init, %0d clamped,",
               n_rsp, n_used, n_init, n_sat);
      $display("across six register settings and three handshake idling mixes.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
